### rtl/spi_pkg.sv
// Package for the similarity profile interpolator.
// Holds fixed widths, state and code enums, the divide/sqrt control struct
// and the magnitude and saturation helpers; shared by the RTL and the checker.
package spi_pkg;

    // Signed Q16.32 value width and derived datapath widths
    localparam int VW    = 48;
    localparam int PW    = 96;   // magnitude product width
    localparam int NUMW  = 142;  // divider numerator width
    localparam int DENW  = 95;   // divider denominator width
    localparam int RADW  = 94;   // square root radicand width
    localparam int ROOTW = 47;   // square root result width
    localparam int CFGW  = 47;   // configuration data width
    localparam int ITW   = 8;    // iteration counter width

    typedef logic signed [VW-1:0] t_val;

    localparam t_val VAL_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_val VAL_MIN = 48'sh8000_0000_0000;

    // Iteration counts of the shared divide/sqrt unit
    localparam logic [ITW-1:0] IT_SCALE  = 8'd142;
    localparam logic [ITW-1:0] IT_INTERP = 8'd96;
    localparam logic [ITW-1:0] IT_SQRT   = 8'd47;

    // Largest radicand whose root still fits: (2^47-1)^2
    localparam logic [NUMW-1:0] SQ_LIM =
        (142'(1) << 94) - (142'(1) << 48) + 142'(1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [1:0] {
        STAT_NORMAL   = 2'd0,
        STAT_INFLOW   = 2'd1,
        STAT_CORNER   = 2'd2,
        STAT_NEGATIVE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_U_INF     = 3'd0,
        CFG_NU        = 3'd1,
        CFG_STATION   = 3'd2,
        CFG_OFFSET    = 3'd3,
        CFG_NONPAR    = 3'd4,
        CFG_TBL_COUNT = 3'd5
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLASS,
        ST_MUL_D,
        ST_DIV_Q,
        ST_SQRT,
        ST_MUL_ETA,
        ST_CHK_LAST,
        ST_MUL_EXT,
        ST_RD_SEG,
        ST_CHK_SEG,
        ST_MUL_DF,
        ST_DIV_F,
        ST_MUL_DG,
        ST_DIV_G,
        ST_MUL_U,
        ST_MUL_ES,
        ST_MUL_FAC,
        ST_MUL_V,
        ST_OUT
    } t_state;

    // Control of the divide/sqrt unit
    typedef struct packed {
        logic           start;
        logic           sqrt_mode;
        logic [ITW-1:0] iters;
    } t_dsq_ctl;

    // Magnitude of a 49-bit signed difference (never reaches -2^48)
    function automatic logic [VW-1:0] mag_of(input logic signed [VW:0] v);
        logic [VW:0] t;
        t = v[VW] ? (~v + 49'd1) : v;
        return t[VW-1:0];
    endfunction

    // Signed result from sign and truncated magnitude, saturated
    function automatic t_val sat_sm(input logic neg, input logic [63:0] m);
        t_val r;
        if (neg) begin
            if (m > 64'h0000_8000_0000_0000) r = VAL_MIN;
            else                             r = t_val'(~m[VW-1:0] + 48'd1);
        end else begin
            if (m > 64'h0000_7FFF_FFFF_FFFF) r = VAL_MAX;
            else                             r = t_val'(m[VW-1:0]);
        end
        return r;
    endfunction

    // Clamp a wide signed sum to the value range
    function automatic t_val sat_s(input logic signed [50:0] v);
        t_val r;
        if (v > 51'sh0_7FFF_FFFF_FFFF)       r = VAL_MAX;
        else if (v < -51'sh0_8000_0000_0000) r = VAL_MIN;
        else                                 r = t_val'(v[VW-1:0]);
        return r;
    endfunction

endpackage

### rtl/similarity_profile_interpolator.sv
// Top level of the similarity profile interpolator: sequencer and datapath.
// Depends on spi_pkg, spi_ram, spi_mul and spi_divsqrt.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    opcode, entry fields, point
//  result    out        o_out_valid / i_out_ready  velocities, eta, f, f', status
//  config    in         i_cfg_we (no wait)         i_cfg_addr, i_cfg_data
//
// An interpolating evaluate runs the 142-step scale divide and the 47-step
// root, then checks the segments from the top and runs the two 96-step
// interpolation divides; each multiply takes three digit steps. A flat segment
// skips both interpolation divides, extrapolation above the table takes one
// multiply instead of the scan and the divides, and a saturated scale skips
// the root.
// Reset is synchronous, active low; the tables hold nothing until loaded.
// A result waits in the output register; the next item is taken meanwhile.
module similarity_profile_interpolator #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_opcode,
    input  logic [9:0]          i_entry_index,
    input  spi_pkg::t_val       i_entry_coordinate,
    input  spi_pkg::t_val       i_entry_stream,
    input  spi_pkg::t_val       i_entry_slope,
    input  spi_pkg::t_val       i_point_x,
    input  spi_pkg::t_val       i_point_y,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spi_pkg::t_val       o_velocity_u,
    output spi_pkg::t_val       o_velocity_v,
    output spi_pkg::t_val       o_similarity_coordinate,
    output spi_pkg::t_val       o_stream_value,
    output spi_pkg::t_val       o_stream_slope,
    output logic [1:0]          o_status,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_addr,
    input  logic [spi_pkg::CFGW-1:0] i_cfg_data
);
    import spi_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    t_state         r_state, n_state;
    logic           r_go;
    logic [CFGW-1:0] r_u_inf, r_nu, r_stx, r_sto;
    logic           r_npm;
    logic [10:0]    r_tbl;

    logic signed [VW:0] r_st;
    t_val           r_y, r_eta, r_val, r_slp, r_u, r_v, r_term;
    t_val           r_c0, r_f0, r_g0, r_c1, r_f1, r_g1;
    logic [ROOTW-1:0] r_s;
    t_val           r_fac;
    t_status        r_status;
    logic [AW-1:0]  r_addr;

    logic           r_ovalid;
    t_val           r_o_u, r_o_v, r_o_eta, r_o_val, r_o_slp;
    t_status        r_o_status;

    logic           in_fire;
    logic           ram_we;
    logic [AW-1:0]  last;
    logic [31:0]    n32;
    t_val           rd_c, rd_f, rd_g;
    logic [VW-1:0]  rd_c_raw, rd_f_raw, rd_g_raw;

    logic           mul_start, mul_done;
    logic [VW-1:0]  mul_a, mul_b;
    logic [PW-1:0]  prod;
    t_dsq_ctl       dsq_ctl;
    logic           dsq_done;
    logic [NUMW-1:0] dsq_num, quo;
    logic [DENW-1:0] dsq_den;
    logic [ROOTW-1:0] root;
    logic [63:0]    prod_hi;

    logic signed [VW:0] d_ec1, d_ec0, d_f, d_g, d_den, d_term;
    logic           eta_above, bracket, seg_flat, scale_max, out_free;
    logic signed [50:0] q_s;
    logic signed [VW:0] n_st;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;
    assign prod_hi  = prod[PW-1:32];

    // entry count clamp
    always_comb begin
        n32 = 32'(r_tbl);
        if (n32 < 32'd2) n32 = 32'd2;
        if (n32 > 32'(TABLE_DEPTH)) n32 = 32'(TABLE_DEPTH);
    end
    assign last = AW'(n32 - 32'd1);

    // profile tables
    assign ram_we = in_fire && (i_opcode == OP_LOAD) &&
                    (32'(i_entry_index) < 32'(TABLE_DEPTH));

    spi_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_ram_coord (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(AW'(i_entry_index)),
        .i_wdata(i_entry_coordinate), .i_raddr(r_addr), .o_rdata(rd_c_raw));
    spi_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_ram_stream (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(AW'(i_entry_index)),
        .i_wdata(i_entry_stream), .i_raddr(r_addr), .o_rdata(rd_f_raw));
    spi_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_ram_slope (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(AW'(i_entry_index)),
        .i_wdata(i_entry_slope), .i_raddr(r_addr), .o_rdata(rd_g_raw));

    assign rd_c = t_val'(rd_c_raw);
    assign rd_f = t_val'(rd_f_raw);
    assign rd_g = t_val'(rd_g_raw);

    // shared arithmetic units
    spi_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_prod(prod));

    spi_divsqrt u_dsq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(dsq_ctl),
        .i_num(dsq_num), .i_den(dsq_den), .i_rad(quo[RADW-1:0]),
        .o_done(dsq_done), .o_quo(quo), .o_root(root));

    // differences and decisions
    assign d_ec1  = {r_eta[VW-1], r_eta} - {r_c1[VW-1], r_c1};
    assign d_ec0  = {r_eta[VW-1], r_eta} - {r_c0[VW-1], r_c0};
    assign d_f    = {r_f1[VW-1], r_f1} - {r_f0[VW-1], r_f0};
    assign d_g    = {r_g1[VW-1], r_g1} - {r_g0[VW-1], r_g0};
    assign d_den  = {r_c1[VW-1], r_c1} - {r_c0[VW-1], r_c0};
    assign d_term = $signed({sat_sm(r_eta[VW-1] ^ r_slp[VW-1], prod_hi), 1'b0}) >>> 1;

    assign eta_above = rd_c < r_eta;
    assign bracket   = (rd_c <= r_eta) && (r_eta <= r_c1);
    assign seg_flat  = rd_c == r_c1;
    assign scale_max = (prod[DENW-1:0] == '0) || (quo >= SQ_LIM);

    // signed interpolation increment
    always_comb begin
        q_s = $signed({1'b0, quo[49:0]});
        if (d_ec0[VW] ^ (r_state == ST_DIV_F ? d_f[VW] : d_g[VW])) q_s = -q_s;
    end

    // station for an evaluate transfer
    assign n_st = r_npm ? ({i_point_x[VW-1], i_point_x} + {2'b0, r_sto})
                        : {2'b0, r_stx};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (in_fire && i_opcode == OP_EVAL) n_state = ST_CLASS;
            ST_CLASS: begin
                if (r_st == '0)      n_state = ST_CHK_LAST;
                else if (r_st[VW])   n_state = ST_OUT;
                else                 n_state = ST_MUL_D;
            end
            ST_MUL_D:    if (mul_done) n_state = ST_DIV_Q;
            ST_DIV_Q:    if (dsq_done) n_state = scale_max ? ST_MUL_ETA : ST_SQRT;
            ST_SQRT:     if (dsq_done) n_state = ST_MUL_ETA;
            ST_MUL_ETA:  if (mul_done) n_state = ST_CHK_LAST;
            ST_CHK_LAST: begin
                if (r_status != STAT_NORMAL) n_state = ST_OUT;
                else if (eta_above)          n_state = ST_MUL_EXT;
                else                         n_state = ST_RD_SEG;
            end
            ST_MUL_EXT:  if (mul_done) n_state = ST_MUL_U;
            ST_RD_SEG:   n_state = ST_CHK_SEG;
            ST_CHK_SEG: begin
                if (bracket)             n_state = seg_flat ? ST_MUL_U : ST_MUL_DF;
                else if (r_addr == '0)   n_state = ST_MUL_U;
                else                     n_state = ST_RD_SEG;
            end
            ST_MUL_DF:   if (mul_done) n_state = ST_DIV_F;
            ST_DIV_F:    if (dsq_done) n_state = ST_MUL_DG;
            ST_MUL_DG:   if (mul_done) n_state = ST_DIV_G;
            ST_DIV_G:    if (dsq_done) n_state = ST_MUL_U;
            ST_MUL_U:    if (mul_done) n_state = ST_MUL_ES;
            ST_MUL_ES:   if (mul_done) n_state = ST_MUL_FAC;
            ST_MUL_FAC:  if (mul_done) n_state = ST_MUL_V;
            ST_MUL_V:    if (mul_done) n_state = ST_OUT;
            ST_OUT:      if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // unit operands and starts
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        dsq_num = '0;
        dsq_den = '0;
        dsq_ctl = '{start: 1'b0, sqrt_mode: 1'b0, iters: IT_SCALE};
        case (r_state)
            ST_MUL_D: begin
                mul_a = VW'(r_nu);
                mul_b = mag_of(r_st);
            end
            ST_MUL_ETA: begin
                mul_a = mag_of({r_y[VW-1], r_y});
                mul_b = VW'(r_s);
            end
            ST_MUL_EXT: begin
                mul_a = mag_of({r_g1[VW-1], r_g1});
                mul_b = mag_of(d_ec1);
            end
            ST_MUL_DF: begin
                mul_a = mag_of(d_ec0);
                mul_b = mag_of(d_f);
            end
            ST_MUL_DG: begin
                mul_a = mag_of(d_ec0);
                mul_b = mag_of(d_g);
            end
            ST_MUL_U: begin
                mul_a = VW'(r_u_inf);
                mul_b = mag_of({r_slp[VW-1], r_slp});
            end
            ST_MUL_ES: begin
                mul_a = mag_of({r_eta[VW-1], r_eta});
                mul_b = mag_of({r_slp[VW-1], r_slp});
            end
            ST_MUL_FAC: begin
                mul_a = VW'(r_nu);
                mul_b = VW'(r_s);
            end
            ST_MUL_V: begin
                mul_a = VW'(r_fac);
                mul_b = mag_of({r_term[VW-1], r_term});
            end
            ST_DIV_Q: begin
                dsq_num = {r_u_inf, 95'b0};
                dsq_den = prod[DENW-1:0];
                dsq_ctl = '{start: r_go, sqrt_mode: 1'b0, iters: IT_SCALE};
            end
            ST_SQRT: begin
                dsq_ctl = '{start: r_go, sqrt_mode: 1'b1, iters: IT_SQRT};
            end
            ST_DIV_F, ST_DIV_G: begin
                dsq_num = {prod, 46'b0};
                dsq_den = DENW'(d_den[VW-1:0]);
                dsq_ctl = '{start: r_go, sqrt_mode: 1'b0, iters: IT_INTERP};
            end
            default: ;
        endcase
    end

    assign mul_start = r_go && (r_state == ST_MUL_D || r_state == ST_MUL_ETA ||
                       r_state == ST_MUL_EXT || r_state == ST_MUL_DF ||
                       r_state == ST_MUL_DG || r_state == ST_MUL_U ||
                       r_state == ST_MUL_ES || r_state == ST_MUL_FAC ||
                       r_state == ST_MUL_V);

    assign o_in_ready = (r_state == ST_IDLE);

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
            r_u_inf  <= CFGW'(64'h1_0000_0000);
            r_nu     <= CFGW'(64'h1_0000_0000);
            r_stx    <= CFGW'(64'h1_0000_0000);
            r_sto    <= CFGW'(64'h1_0000_0000);
            r_npm    <= 1'b0;
            r_tbl    <= 11'd2;
        end else begin
            r_state <= n_state;
            r_go    <= (n_state != r_state);
            if (r_state == ST_OUT && out_free) r_ovalid <= 1'b1;
            else if (i_out_ready)              r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_U_INF:     r_u_inf <= i_cfg_data;
                    CFG_NU:        r_nu    <= i_cfg_data;
                    CFG_STATION:   r_stx   <= i_cfg_data;
                    CFG_OFFSET:    r_sto   <= i_cfg_data;
                    CFG_NONPAR:    r_npm   <= i_cfg_data[0];
                    CFG_TBL_COUNT: r_tbl   <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath captures
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_y      <= i_point_y;
                    r_st     <= n_st;
                    r_addr   <= last;
                    r_status <= STAT_NORMAL;
                end
            end
            ST_CLASS: begin
                if (r_st == '0) begin
                    r_status <= (r_y == '0) ? STAT_CORNER : STAT_INFLOW;
                end else if (r_st[VW]) begin
                    r_status <= STAT_NEGATIVE;
                    r_u      <= '0;
                    r_v      <= '0;
                    r_eta    <= '0;
                    r_val    <= '0;
                    r_slp    <= '0;
                end
            end
            ST_DIV_Q: if (dsq_done && scale_max) r_s <= '1;
            ST_SQRT:  if (dsq_done) r_s <= root;
            ST_MUL_ETA: begin
                if (mul_done) r_eta <= sat_sm(r_y[VW-1], prod_hi);
            end
            ST_CHK_LAST: begin
                r_c1 <= rd_c;
                r_f1 <= rd_f;
                r_g1 <= rd_g;
                if (r_status != STAT_NORMAL) begin
                    r_eta <= VAL_MAX;
                    r_val <= rd_f;
                    r_slp <= rd_g;
                    r_v   <= '0;
                    r_u   <= (r_status == STAT_INFLOW) ? t_val'({1'b0, r_u_inf}) : '0;
                end else if (!eta_above) begin
                    r_addr <= last - AW'(1);
                end
            end
            ST_MUL_EXT: begin
                if (mul_done) begin
                    r_val <= sat_s({{3{r_f1[VW-1]}}, r_f1} +
                                   {{3{r_g1[VW-1]}}, sat_sm(r_g1[VW-1], prod_hi)});
                    r_slp <= r_g1;
                end
            end
            ST_CHK_SEG: begin
                if (bracket) begin
                    r_c0 <= rd_c;
                    r_f0 <= rd_f;
                    r_g0 <= rd_g;
                    if (seg_flat) begin
                        r_val <= rd_f;
                        r_slp <= rd_g;
                    end
                end else begin
                    r_c1 <= rd_c;
                    r_f1 <= rd_f;
                    r_g1 <= rd_g;
                    if (r_addr == '0) begin
                        r_val <= '0;
                        r_slp <= '0;
                    end else begin
                        r_addr <= r_addr - AW'(1);
                    end
                end
            end
            ST_DIV_F: if (dsq_done) r_val <= sat_s({{3{r_f0[VW-1]}}, r_f0} + q_s);
            ST_DIV_G: if (dsq_done) r_slp <= sat_s({{3{r_g0[VW-1]}}, r_g0} + q_s);
            ST_MUL_U: if (mul_done) r_u <= sat_sm(r_slp[VW-1], prod_hi);
            ST_MUL_ES: begin
                if (mul_done) begin
                    r_term <= sat_s({{2{d_term[VW]}}, d_term} -
                                    {{3{r_val[VW-1]}}, r_val});
                end
            end
            ST_MUL_FAC: if (mul_done) r_fac <= sat_sm(1'b0, prod_hi);
            ST_MUL_V:   if (mul_done) r_v <= sat_sm(r_term[VW-1], prod_hi);
            ST_OUT: begin
                if (out_free) begin
                    r_o_u      <= r_u;
                    r_o_v      <= r_v;
                    r_o_eta    <= r_eta;
                    r_o_val    <= r_val;
                    r_o_slp    <= r_slp;
                    r_o_status <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid             = r_ovalid;
    assign o_velocity_u            = r_o_u;
    assign o_velocity_v            = r_o_v;
    assign o_similarity_coordinate = r_o_eta;
    assign o_stream_value          = r_o_val;
    assign o_stream_slope          = r_o_slp;
    assign o_status                = r_o_status;
endmodule

### rtl/spi_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module spi_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/spi_mul.sv
// Shared sequential multiplier: 48 x 48 magnitudes, 16-bit digit per cycle.
// Depends on spi_pkg.
module spi_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [spi_pkg::VW-1:0] i_a,
    input  logic [spi_pkg::VW-1:0] i_b,
    output logic                  o_done,
    output logic [spi_pkg::PW-1:0] o_prod
);
    import spi_pkg::*;

    logic          r_busy;
    logic          r_done;
    logic [1:0]    r_cnt;
    logic [VW-1:0] r_a;
    logic [VW-1:0] r_b;
    logic [PW-1:0] r_acc;
    logic [63:0]   pp;

    // partial product of the top remaining digit
    assign pp = 64'(r_a) * 64'(r_b[VW-1:VW-16]);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd3;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 2'd1;
                if (r_cnt == 2'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // accumulate most significant digit first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[PW-17:0], 16'b0} + {32'b0, pp};
            r_b   <= {r_b[VW-17:0], 16'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

### rtl/spi_divsqrt.sv
// Shared restoring divider and digit-by-digit square root, one bit per cycle.
// Depends on spi_pkg.
module spi_divsqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  spi_pkg::t_dsq_ctl         i_ctl,
    input  logic [spi_pkg::NUMW-1:0]  i_num,
    input  logic [spi_pkg::DENW-1:0]  i_den,
    input  logic [spi_pkg::RADW-1:0]  i_rad,
    output logic                      o_done,
    output logic [spi_pkg::NUMW-1:0]  o_quo,
    output logic [spi_pkg::ROOTW-1:0] o_root
);
    import spi_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic             r_mode;
    logic [ITW-1:0]   r_cnt;
    logic [NUMW-1:0]  r_num;
    logic [DENW-1:0]  r_den;
    logic [DENW-1:0]  r_rem;
    logic [NUMW-1:0]  r_quo;
    logic [RADW-1:0]  r_rad;
    logic [ROOTW+1:0] r_srem;
    logic [ROOTW-1:0] r_root;

    logic [DENW:0]    rem_sh;
    logic [DENW:0]    rem_dif;
    logic             div_ge;
    logic [ROOTW+3:0] srem_sh;
    logic [ROOTW+3:0] trial;
    logic [ROOTW+3:0] srem_dif;
    logic             sq_ge;

    // one division step
    assign rem_sh  = {r_rem, r_num[NUMW-1]};
    assign rem_dif = rem_sh - {1'b0, r_den};
    assign div_ge  = rem_sh >= {1'b0, r_den};

    // one root step
    assign srem_sh  = {r_srem, r_rad[RADW-1:RADW-2]};
    assign trial    = {2'b0, r_root, 2'b01};
    assign srem_dif = srem_sh - trial;
    assign sq_ge    = srem_sh >= trial;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.iters;
                r_mode <= i_ctl.sqrt_mode;
            end else if (r_busy) begin
                r_cnt <= r_cnt - ITW'(1);
                if (r_cnt == ITW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= '0;
            r_rad  <= i_rad;
            r_srem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            if (r_mode) begin
                r_srem <= sq_ge ? srem_dif[ROOTW+1:0] : srem_sh[ROOTW+1:0];
                r_root <= {r_root[ROOTW-2:0], sq_ge};
                r_rad  <= {r_rad[RADW-3:0], 2'b0};
            end else begin
                r_rem <= div_ge ? rem_dif[DENW-1:0] : rem_sh[DENW-1:0];
                r_quo <= {r_quo[NUMW-2:0], div_ge};
                r_num <= {r_num[NUMW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_root = r_root;
endmodule

### rtl/spi_checker.sv
// Port-level checker for the similarity profile interpolator, with its bind.
// Depends on spi_pkg.
module spi_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                i_opcode,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  spi_pkg::t_val       o_velocity_u,
    input  spi_pkg::t_val       o_velocity_v,
    input  spi_pkg::t_val       o_similarity_coordinate,
    input  logic [1:0]          o_status
);
    import spi_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_velocity_u))
        else $error("stalled result changed");

    // an evaluate occupies the sequencer
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_opcode == OP_EVAL |=> !o_in_ready)
        else $error("input ready right after evaluate");

    // a load produces no result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_opcode == OP_LOAD && !o_out_valid
        |=> !o_out_valid)
        else $error("result after load");

    // negative station reports zeros
    a_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STAT_NEGATIVE |->
        o_velocity_u == '0 && o_velocity_v == '0 && o_similarity_coordinate == '0)
        else $error("negative station with nonzero result");
endmodule

bind similarity_profile_interpolator spi_checker u_spi_checker (.*);

### tb/similarity_profile_interpolator_test.sv
// Self-checking testbench for similarity_profile_interpolator: random bursts of table loads
// and point evaluations, checked against a bit-exact profile interpolation predictor.
// Depends on spi_pkg and the RTL top level only.
module similarity_profile_interpolator_test;
    import spi_pkg::*;

    localparam t_val ONE = 48'sh1_0000_0000;
    localparam logic [CFGW-1:0] CFG_ONE = 47'h1_0000_0000;
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int DEPTH = 1024;
    localparam int FILL = 64;
    localparam int RANDOM_ITEMS = 600;

    typedef struct {
        logic       op;
        logic [9:0] idx;
        t_val       coord, strm, slp, px, py;
    } t_item;

    typedef struct {
        t_val    u, v, eta, f, g;
        t_status status;
    } t_flow;

    // sign and magnitude form used by the predictor
    typedef struct {
        bit        neg;
        bit [63:0] mag;
    } t_sm;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_ready;
    logic            i_opcode = OP_LOAD;
    logic [9:0]      i_entry_index = '0;
    t_val            i_entry_coordinate = '0;
    t_val            i_entry_stream = '0;
    t_val            i_entry_slope = '0;
    t_val            i_point_x = '0;
    t_val            i_point_y = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    t_val            o_velocity_u, o_velocity_v, o_similarity_coordinate;
    t_val            o_stream_value, o_stream_slope;
    logic [1:0]      o_status;
    logic            i_cfg_we = 1'b0;
    logic [2:0]      i_cfg_addr = '0;
    logic [CFGW-1:0] i_cfg_data = '0;

    similarity_profile_interpolator dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state: configuration and profile tables
    logic [46:0] cfg_u, cfg_nu, cfg_station, cfg_offset;
    logic        cfg_nonpar;
    logic [10:0] cfg_count;
    t_val        tab_coord [DEPTH];
    t_val        tab_f [DEPTH];
    t_val        tab_g [DEPTH];

    t_item pend_items[$];
    t_flow expected_flow[$];
    int    errors = 0;

    // ---------------- fixed point helpers ----------------
    function automatic t_sm sm_pos(input logic [63:0] m);
        t_sm r;
        r.neg = 1'b0;
        r.mag = m;
        return r;
    endfunction

    function automatic t_sm sm_from(input t_val raw);
        t_sm r;
        logic [47:0] t;
        t = ~raw + 48'd1;
        r.neg = raw[47];
        r.mag = r.neg ? 64'(t) : 64'(raw);
        return r;
    endfunction

    function automatic t_val sm_to(input t_sm a);
        if (a.neg) begin
            if (a.mag == 0) return '0;
            if (a.mag > 64'h8000_0000_0000) return VAL_MIN;
            return t_val'(~a.mag[47:0] + 48'd1);
        end
        if (a.mag > 64'h7FFF_FFFF_FFFF) return VAL_MAX;
        return t_val'(a.mag[47:0]);
    endfunction

    function automatic t_sm sm_clamp(input t_sm a);
        return sm_from(sm_to(a));
    endfunction

    function automatic t_sm sm_flip(input t_sm a);
        a.neg = ~a.neg;
        return a;
    endfunction

    function automatic t_sm sm_sum(input t_sm a, input t_sm b);
        t_sm r;
        logic [64:0] s;
        if (a.neg == b.neg) begin
            s = {1'b0, a.mag} + {1'b0, b.mag};
            r.neg = a.neg;
            r.mag = s[64] ? '1 : s[63:0];
        end else if (a.mag >= b.mag) begin
            r.neg = a.neg;
            r.mag = a.mag - b.mag;
        end else begin
            r.neg = b.neg;
            r.mag = b.mag - a.mag;
        end
        return r;
    endfunction

    // Q32 product, truncated and saturated
    function automatic t_sm mul_q(input t_sm a, input t_sm b);
        t_sm r;
        logic [127:0] p;
        p = 128'(a.mag) * 128'(b.mag);
        r.neg = a.neg ^ b.neg;
        r.mag = (|p[127:96]) ? '1 : p[95:32];
        return sm_clamp(r);
    endfunction

    // a*b/den with truncated quotient, not clamped to the value range
    function automatic t_sm mul_div(input t_sm a, input t_sm b, input logic [63:0] den);
        t_sm r;
        logic [127:0] q;
        q = (128'(a.mag) * 128'(b.mag)) / 128'(den);
        r.neg = a.neg ^ b.neg;
        r.mag = (|q[127:64]) ? '1 : q[63:0];
        return r;
    endfunction

    function automatic bit key_lt(input t_val a, input t_val b);
        return {~a[47], a[46:0]} < {~b[47], b[46:0]};
    endfunction

    // largest root r with r^2 * 2*nu*station <= U (all Q32)
    function automatic logic [63:0] scale_of(input logic [63:0] st);
        logic [255:0] d, tgt, c;
        logic [63:0]  r;
        d = 256'(cfg_nu) * 256'(st);
        tgt = 256'(cfg_u) << 95;
        r = '0;
        for (int b = 46; b >= 0; b--) begin
            c = 256'(r | (64'd1 << b));
            if (c * c * d <= tgt) r = c[63:0];
        end
        return r;
    endfunction

    // table lookup: extrapolate above, highest bracketing segment otherwise
    function automatic void profile_lookup(input t_sm eta, input int n,
                                           output t_sm f, output t_sm g);
        int   last;
        t_val er, c0, c1;
        t_sm  den, d, f0, g0;
        last = n - 1;
        er = sm_to(eta);
        f = sm_pos(0);
        g = sm_pos(0);
        if (key_lt(tab_coord[last], er)) begin
            d = sm_sum(eta, sm_flip(sm_from(tab_coord[last])));
            g = sm_from(tab_g[last]);
            f = sm_clamp(sm_sum(sm_from(tab_f[last]), mul_q(g, d)));
            return;
        end
        for (int j = n - 2; j >= 0; j--) begin
            c0 = tab_coord[j];
            c1 = tab_coord[j+1];
            if (!key_lt(er, c0) && !key_lt(c1, er)) begin
                den = sm_sum(sm_from(c1), sm_flip(sm_from(c0)));
                d = sm_sum(eta, sm_flip(sm_from(c0)));
                f0 = sm_from(tab_f[j]);
                g0 = sm_from(tab_g[j]);
                if (den.mag == 0) begin
                    f = f0;
                    g = g0;
                end else begin
                    f = sm_clamp(sm_sum(f0, mul_div(d,
                        sm_sum(sm_from(tab_f[j+1]), sm_flip(f0)), den.mag)));
                    g = sm_clamp(sm_sum(g0, mul_div(d,
                        sm_sum(sm_from(tab_g[j+1]), sm_flip(g0)), den.mag)));
                end
                return;
            end
        end
    endfunction

    // apply one accepted transfer; returns 1 when it yields a flow result
    function automatic bit flow_predict(input t_item it, output t_flow res);
        int      n;
        t_sm     y, st, s, eta, f, g, u, v, term, fac;
        t_status stat;
        if (it.op == OP_LOAD) begin
            tab_coord[it.idx] = it.coord;
            tab_f[it.idx] = it.strm;
            tab_g[it.idx] = it.slp;
            return 1'b0;
        end
        n = (cfg_count < 2) ? 2 : (cfg_count > DEPTH) ? DEPTH : int'(cfg_count);
        y = sm_from(it.py);
        st = cfg_nonpar ? sm_sum(sm_from(it.px), sm_pos(64'(cfg_offset)))
                        : sm_pos(64'(cfg_station));
        if (st.mag == 0) begin
            stat = (y.mag == 0) ? STAT_CORNER : STAT_INFLOW;
            u = sm_pos(stat == STAT_INFLOW ? 64'(cfg_u) : 64'd0);
            v = sm_pos(0);
            eta = sm_pos(64'(VAL_MAX));
            f = sm_from(tab_f[n-1]);
            g = sm_from(tab_g[n-1]);
        end else if (st.neg) begin
            stat = STAT_NEGATIVE;
            u = sm_pos(0);
            v = u; eta = u; f = u; g = u;
        end else begin
            stat = STAT_NORMAL;
            s = sm_pos(scale_of(st.mag));
            eta = mul_q(y, s);
            profile_lookup(eta, n, f, g);
            u = mul_q(sm_pos(64'(cfg_u)), g);
            term = sm_clamp(sm_sum(mul_q(eta, g), sm_flip(f)));
            fac = mul_q(sm_pos(64'(cfg_nu)), s);
            v = mul_q(fac, term);
        end
        res.u = sm_to(u);
        res.v = sm_to(v);
        res.eta = sm_to(eta);
        res.f = sm_to(f);
        res.g = sm_to(g);
        res.status = stat;
        return 1'b1;
    endfunction

    // ---------------- input driver ----------------
    t_item cur_item;
    int    burst_left = 0;
    int    gap_left = 0;

    always @(posedge i_clk) begin
        t_flow res;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (flow_predict(cur_item, res)) expected_flow = {expected_flow, res};
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pend_items.size() > 0) begin
                    cur_item = pend_items.pop_front();
                    i_opcode <= cur_item.op;
                    i_entry_index <= cur_item.idx;
                    i_entry_coordinate <= cur_item.coord;
                    i_entry_stream <= cur_item.strm;
                    i_entry_slope <= cur_item.slp;
                    i_point_x <= cur_item.px;
                    i_point_y <= cur_item.py;
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result monitor ----------------
    int stall_mode = 0;
    int stall_cnt = 0;
    int cyc = 0;

    task automatic check_field(input string name, input logic [47:0] exp_v,
                               input logic [47:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_flow e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            cyc++;
            if (o_out_valid && i_out_ready) begin
                if (expected_flow.size() == 0) begin
                    errors++;
                    $display("%0t: result transfer with nothing expected: expected none, actual u=%h",
                             $time, o_velocity_u);
                end else begin
                    e = expected_flow.pop_front();
                    check_field("velocity_u", e.u, o_velocity_u);
                    check_field("velocity_v", e.v, o_velocity_v);
                    check_field("similarity_coordinate", e.eta, o_similarity_coordinate);
                    check_field("stream_value", e.f, o_stream_value);
                    check_field("stream_slope", e.g, o_stream_slope);
                    check_field("status", 48'(e.status), 48'(o_status));
                end
            end
            // receiver stall pattern: free running, random, sparse, periodic
            if (stall_cnt == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_cnt = $urandom_range(20, 300);
            end else begin
                stall_cnt--;
            end
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= $urandom_range(0, 1);
                2: i_out_ready <= ($urandom_range(0, 15) == 0);
                default: i_out_ready <= ((cyc % 11) > 6);
            endcase
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic t_val rand48();
        return t_val'({$urandom, $urandom});
    endfunction

    // random value of about +/-64.0
    function automatic t_val rand_near();
        return rand48() >>> 9;
    endfunction

    function automatic logic [CFGW-1:0] pick_cfg(input bit allow_zero);
        logic [CFGW-1:0] v;
        case ($urandom_range(0, 5))
            0: v = CFGW'(1);
            1: v = '1;
            2: v = CFG_ONE;
            3: v = CFGW'(64'($urandom_range(1, 32'hFFFF)) << $urandom_range(16, 40));
            4: v = CFGW'({$urandom, $urandom});
            default: v = allow_zero ? '0 : CFG_ONE;
        endcase
        if (v == 0 && !allow_zero) v = CFGW'(1);
        return v;
    endfunction

    task automatic push_load(input int idx, input t_val c, input t_val f, input t_val g);
        t_item it;
        it.op = OP_LOAD;
        it.idx = 10'(idx);
        it.coord = c;
        it.strm = f;
        it.slp = g;
        it.px = rand48();
        it.py = rand48();
        pend_items = {pend_items, it};
    endtask

    task automatic push_eval(input t_val x, input t_val y);
        t_item it;
        it.op = OP_EVAL;
        it.idx = 10'($urandom);
        it.coord = rand48();
        it.strm = rand48();
        it.slp = rand48();
        it.px = x;
        it.py = y;
        pend_items = {pend_items, it};
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [CFGW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_U_INF:     cfg_u = val;
            CFG_NU:        cfg_nu = val;
            CFG_STATION:   cfg_station = val;
            CFG_OFFSET:    cfg_offset = val;
            CFG_NONPAR:    cfg_nonpar = val[0];
            CFG_TBL_COUNT: cfg_count = val[10:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for every transfer and result, then let a trailing load settle
    task automatic wait_idle(input int settle);
        @(negedge i_clk);
        while (pend_items.size() != 0 || i_in_valid || expected_flow.size() != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // ---------------- test sequence ----------------
    initial begin
        int items_left, phase_items, n_sel;
        t_val y, x;
        cfg_u = CFG_ONE;
        cfg_nu = CFG_ONE;
        cfg_station = CFG_ONE;
        cfg_offset = CFG_ONE;
        cfg_nonpar = 1'b0;
        cfg_count = 11'd2;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: scale of exactly 1.0 so eta equals y
        cfg_write(CFG_U_INF, CFG_ONE << 1);
        cfg_write(CFG_NU, CFG_ONE);
        cfg_write(CFG_STATION, CFG_ONE);
        cfg_write(CFG_OFFSET, CFG_ONE);
        cfg_write(CFG_NONPAR, '0);
        cfg_write(CFG_TBL_COUNT, CFGW'(8));
        cfg_write(CFG_UNUSED, '1);
        @(negedge i_clk);
        push_load(1023, VAL_MAX, VAL_MIN, VAL_MAX);
        push_load(1022, VAL_MIN, VAL_MAX, VAL_MIN);
        for (int k = 0; k < 8; k++)
            // last two coordinates equal: zero-width top segment
            push_load(k, (k == 7) ? 6 * ONE : k * ONE, k * (ONE >>> 1),
                      (k % 2) ? -(k * (ONE >>> 2)) : k * (ONE >>> 2));
        push_eval('0, '0);
        push_eval('0, ONE >>> 1);
        push_eval('0, 3 * ONE);
        push_eval('0, 6 * ONE);          // zero-width segment
        push_eval('0, 6 * ONE + (ONE >>> 1)); // above the table
        push_eval('0, -ONE);             // below the table
        push_eval('0, VAL_MAX);
        push_eval('0, VAL_MIN);
        wait_idle(40);

        // directed: station from point x
        cfg_write(CFG_NONPAR, CFGW'(1));
        @(negedge i_clk);
        push_eval(-ONE, '0);            // zero station at the wall
        push_eval(-ONE, ONE);           // zero station, inflow
        push_eval(-2 * ONE, ONE);       // negative station
        push_eval(VAL_MAX, ONE);
        push_eval(VAL_MIN, VAL_MAX);
        wait_idle(40);

        // fill the low slots with an ascending profile
        cfg_write(CFG_NONPAR, '0);
        @(negedge i_clk);
        for (int k = 0; k < FILL; k++)
            push_load(k, t_val'(k) <<< 30, rand_near() >>> 4, rand_near() >>> 6);
        wait_idle(40);

        // random phases
        items_left = RANDOM_ITEMS;
        while (items_left > 0) begin
            cfg_write(CFG_U_INF, pick_cfg(1'b0));
            cfg_write(CFG_NU, pick_cfg(1'b0));
            cfg_write(CFG_STATION, pick_cfg(1'b0));
            cfg_write(CFG_OFFSET, pick_cfg(1'b1));
            cfg_write(CFG_NONPAR, CFGW'($urandom_range(0, 1)));
            if ($urandom_range(0, 6) == 0) begin
                case ($urandom_range(0, 3))
                    0: n_sel = 0;
                    1: n_sel = 1;
                    2: n_sel = 2;
                    default: n_sel = FILL;
                endcase
            end else begin
                n_sel = $urandom_range(2, 40);
            end
            cfg_write(CFG_TBL_COUNT, CFGW'(n_sel));
            if ($urandom_range(0, 3) == 0) cfg_write(CFG_UNUSED - 3'd1, pick_cfg(1'b1));
            phase_items = $urandom_range(20, 60);
            @(negedge i_clk);
            for (int i = 0; i < phase_items; i++) begin
                if ($urandom_range(0, 99) < 35) begin
                    if ($urandom_range(0, 1))
                        push_load($urandom_range(0, 63), t_val'($urandom_range(0, 63)) <<< 30,
                                  rand_near(), rand_near() >>> 4);
                    else
                        push_load($urandom_range(0, DEPTH - 1), rand48(), rand48(), rand48());
                end else begin
                    case ($urandom_range(0, 9))
                        0: y = rand48();
                        1: y = VAL_MAX;
                        2: y = VAL_MIN;
                        3: y = '0;
                        default: y = rand_near();
                    endcase
                    case ($urandom_range(0, 9))
                        0, 1: x = rand48();
                        2: x = -t_val'(cfg_offset);
                        default: x = rand_near();
                    endcase
                    push_eval(x, y);
                end
            end
            items_left -= phase_items;
            wait_idle(40);
        end

        wait_idle(2600);
        if (errors == 0 && expected_flow.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
